// ----- design/assert_macros.svh -----
// assertion macros shared by the allocator rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

// ----- design/bfpa_pkg.sv -----
// shared codes for the best-fit page allocator
`default_nettype none
package bfpa_pkg;
    localparam logic [1:0] FUNC_ALLOC = 2'd0;
    localparam logic [1:0] FUNC_FREE  = 2'd1;
    localparam logic [1:0] FUNC_QUERY = 2'd2;
    localparam logic [1:0] FUNC_NOP   = 2'd3;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_BAD_OFFSET = 2'd1;
    localparam logic [1:0] ST_NOT_USED   = 2'd2;
    localparam logic [1:0] ST_NO_FIT     = 2'd3;

    localparam int IN_BITS  = 48;
    localparam int OUT_BITS = 104;
endpackage
`default_nettype wire

// ----- design/bfpa_ram.sv -----
// generic simple dual-port ram with registered read
`default_nettype none
module bfpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ----- design/best_fit_page_allocator_unit.sv -----
// top level of the best-fit page allocator with coalescing
//
// channel   dir  width  contents
// s_axis    in   48     func[1:0], length_bytes[22:2], offset_bytes[43:23]
// m_axis    out  104    status, address, block_bytes, chunk_empty,
//                       largest_free_pages, largest_changed
// cfg       in   64     chunk_base
//
// one item at a time; a successful allocate or free makes a full sweep of the
// block table ram, then a second sweep for the largest free run;
// query, failed allocate and rejected free make the first sweep only; nop makes none
// all sweeps are bound by the single ram read port
// after reset a clearing pass writes every table entry; no item taken
// a result waits in the output register while the next item is accepted
`default_nettype none
`include "assert_macros.svh"
module best_fit_page_allocator_unit #(
    parameter int UNITS      = 256,
    parameter int PAGE_BYTES = 4096
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    // func, length_bytes, offset_bytes, zero fill
    input  wire logic [bfpa_pkg::IN_BITS-1:0] s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    // status, address, block_bytes, chunk_empty, largest_free_pages,
    // largest_changed, zero fill
    output logic [bfpa_pkg::OUT_BITS-1:0]     m_axis_tdata,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [63:0]                  cfg_data
);
    import bfpa_pkg::*;

    localparam int IW  = $clog2(UNITS);
    localparam int RW  = $clog2(UNITS);
    localparam int EW  = RW + 2;
    localparam int SH  = $clog2(PAGE_BYTES);
    localparam int NW  = 22 - SH;
    localparam int PGW = 21 - SH;
    localparam int XW  = 24;
    localparam int LW  = (RW > 8) ? RW : 8;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_SCAN  = 4'd2;
    localparam logic [3:0] S_EVAL  = 4'd3;
    localparam logic [3:0] S_W1    = 4'd4;
    localparam logic [3:0] S_W2    = 4'd5;
    localparam logic [3:0] S_W3    = 4'd6;
    localparam logic [3:0] S_LSCAN = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    logic [3:0]     state_reg, state_next;
    logic [IW:0]    idx_reg, idx_next;
    logic           dv_reg, dv_next;
    logic [IW-1:0]  didx_reg, didx_next;
    logic [1:0]     func_reg, func_next;
    logic [NW-1:0]  need_reg, need_next;
    logic [PGW-1:0] page_reg, page_next;
    logic           bad_reg, bad_next;
    logic [63:0]    base_reg, base_next;
    logic [IW-1:0]  best_reg, best_next;
    logic [RW-1:0]  bsize_reg, bsize_next;
    logic           bfound_reg, bfound_next;
    logic [IW-1:0]  pv_reg, pv_next;
    logic           pvf_reg, pvf_next;
    logic           pvfree_reg, pvfree_next;
    logic [RW-1:0]  pvrun_reg, pvrun_next;
    logic           pgs_reg, pgs_next;
    logic           pgu_reg, pgu_next;
    logic [IW-1:0]  nx_reg, nx_next;
    logic           nxf_reg, nxf_next;
    logic           nxfree_reg, nxfree_next;
    logic [RW-1:0]  nxrun_reg, nxrun_next;
    logic [RW-1:0]  total_reg, total_next;
    logic [IW:0]    fpc_reg, fpc_next;
    logic [RW-1:0]  largest_reg, largest_next;
    logic [RW-1:0]  lmax_reg, lmax_next;
    logic           changed_reg, changed_next;
    logic [1:0]     status_reg, status_next;
    logic [63:0]    addr_reg, addr_next;
    logic [20:0]    bytes_reg, bytes_next;
    logic           empty_reg, empty_next;
    logic           ov_reg, ov_next;
    logic [OUT_BITS-1:0] od_reg, od_next;

    logic          we;
    logic [IW-1:0] waddr, raddr;
    logic [EW-1:0] wdata, rdata;
    logic          e_s, e_u;
    logic [RW-1:0] e_r;
    logic [21:0]   need_sum;
    logic [IW:0]   nxend, own;
    logic [IW+1:0] tot_w;
    logic          mnx, mpv;
    logic [LW-1:0] lsat;
    logic          in_acc;

    bfpa_ram #(.WIDTH(EW), .DEPTH(UNITS)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign e_s = rdata[RW+1];
    assign e_u = rdata[RW];
    assign e_r = rdata[RW-1:0];
    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign cfg_ready = 1'b1;
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata = od_reg;
    assign need_sum = 22'(s_axis_tdata[22:2]) + 22'(PAGE_BYTES - 1);
    assign nxend = nxf_reg ? {1'b0, nx_reg} : (IW+1)'(UNITS);
    assign own = (IW+1)'(XW'(nxend) - XW'(page_reg));
    assign mnx = nxf_reg && nxfree_reg;
    assign mpv = pvf_reg && pvfree_reg;
    assign tot_w = (IW+2)'(own) + (mnx ? (IW+2)'(nxrun_reg) : '0)
                 + (mpv ? (IW+2)'(pvrun_reg) : '0);
    assign lsat = (LW'(largest_reg) > LW'(255)) ? LW'(255) : LW'(largest_reg);

    always_comb
    begin
        state_next = state_reg;   idx_next = idx_reg;       dv_next = 1'b0;
        didx_next = idx_reg[IW-1:0];
        func_next = func_reg;     need_next = need_reg;     page_next = page_reg;
        bad_next = bad_reg;       base_next = base_reg;
        best_next = best_reg;     bsize_next = bsize_reg;   bfound_next = bfound_reg;
        pv_next = pv_reg;         pvf_next = pvf_reg;       pvfree_next = pvfree_reg;
        pvrun_next = pvrun_reg;   pgs_next = pgs_reg;       pgu_next = pgu_reg;
        nx_next = nx_reg;         nxf_next = nxf_reg;       nxfree_next = nxfree_reg;
        nxrun_next = nxrun_reg;   total_next = total_reg;   fpc_next = fpc_reg;
        largest_next = largest_reg; lmax_next = lmax_reg;   changed_next = changed_reg;
        status_next = status_reg; addr_next = addr_reg;     bytes_next = bytes_reg;
        empty_next = empty_reg;   ov_next = ov_reg;         od_next = od_reg;
        we = 1'b0;
        waddr = '0;
        wdata = '0;
        raddr = idx_reg[IW-1:0];

        if (ov_reg && m_axis_tready)
        begin
            ov_next = 1'b0;
        end
        if (cfg_valid)
        begin
            base_next = cfg_data;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                we = 1'b1;
                waddr = idx_reg[IW-1:0];
                wdata = (idx_reg == (IW+1)'(1)) ? {2'b10, RW'(UNITS - 1)} : '0;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == (IW+1)'(UNITS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_acc)
                begin
                    func_next = s_axis_tdata[1:0];
                    need_next = NW'(need_sum >> SH);
                    page_next = s_axis_tdata[43:23+SH];
                    bad_next = (s_axis_tdata[23+SH-1:23] != '0)
                            || (XW'(s_axis_tdata[43:23+SH]) >= XW'(UNITS));
                    bfound_next = 1'b0; pvf_next = 1'b0; nxf_next = 1'b0;
                    pgs_next = 1'b0;    pgu_next = 1'b0;
                    changed_next = 1'b0; status_next = ST_OK;
                    addr_next = '0; bytes_next = '0; empty_next = 1'b0;
                    idx_next = '0;
                    state_next = (s_axis_tdata[1:0] == FUNC_NOP) ? S_OUT : S_SCAN;
                end
            end
            S_SCAN, S_LSCAN:
            begin
                if (idx_reg != (IW+1)'(UNITS))
                begin
                    idx_next = idx_reg + 1'b1;
                    dv_next = 1'b1;
                end
                if (dv_reg)
                begin
                    if (state_reg == S_LSCAN)
                    begin
                        if (e_s && !e_u && e_r > lmax_reg)
                        begin
                            lmax_next = e_r;
                        end
                    end
                    else if (func_reg == FUNC_ALLOC)
                    begin
                        if (e_s && !e_u && XW'(e_r) >= XW'(need_reg)
                            && (!bfound_reg || e_r < bsize_reg))
                        begin
                            best_next = didx_reg;
                            bsize_next = e_r;
                            bfound_next = 1'b1;
                        end
                    end
                    else
                    begin
                        if (XW'(didx_reg) < XW'(page_reg) && e_s)
                        begin
                            pv_next = didx_reg; pvf_next = 1'b1;
                            pvfree_next = !e_u; pvrun_next = e_r;
                        end
                        if (XW'(didx_reg) == XW'(page_reg))
                        begin
                            pgs_next = e_s;
                            pgu_next = e_u;
                        end
                        if (XW'(didx_reg) > XW'(page_reg) && e_s && !nxf_reg)
                        begin
                            nx_next = didx_reg; nxf_next = 1'b1;
                            nxfree_next = !e_u; nxrun_next = e_r;
                        end
                    end
                    if (didx_reg == IW'(UNITS - 1))
                    begin
                        if (state_reg == S_LSCAN)
                        begin
                            largest_next = lmax_next;
                            changed_next = (lmax_next != largest_reg);
                            state_next = S_OUT;
                        end
                        else
                        begin
                            state_next = S_EVAL;
                        end
                    end
                end
            end
            S_EVAL:
            begin
                state_next = S_OUT;
                if (func_reg == FUNC_ALLOC)
                begin
                    if (need_reg == '0 || !bfound_reg)
                    begin
                        status_next = ST_NO_FIT;
                    end
                    else
                    begin
                        addr_next = base_reg + (64'(best_reg) << SH);
                        fpc_next = fpc_reg - (IW+1)'(need_reg);
                        state_next = S_W1;
                    end
                end
                else if (bad_reg)
                begin
                    status_next = ST_BAD_OFFSET;
                end
                else if (!(pgs_reg && pgu_reg))
                begin
                    status_next = ST_NOT_USED;
                end
                else if (func_reg == FUNC_QUERY)
                begin
                    bytes_next = 21'(XW'(own) << SH);
                end
                else
                begin
                    total_next = RW'(tot_w);
                    fpc_next = fpc_reg + own;
                    empty_next = ((fpc_reg + own) == (IW+1)'(UNITS - 1));
                    state_next = S_W1;
                end
            end
            S_W1:
            begin
                if (func_reg == FUNC_ALLOC)
                begin
                    we = 1'b1;
                    waddr = best_reg;
                    wdata = {2'b11, RW'(0)};
                end
                else
                begin
                    we = mnx;
                    waddr = nx_reg;
                    wdata = '0;
                end
                state_next = S_W2;
            end
            S_W2:
            begin
                if (func_reg == FUNC_ALLOC)
                begin
                    we = XW'(bsize_reg) > XW'(need_reg);
                    waddr = IW'(XW'(best_reg) + XW'(need_reg));
                    wdata = {2'b10, RW'(XW'(bsize_reg) - XW'(need_reg))};
                end
                else
                begin
                    we = 1'b1;
                    waddr = IW'(page_reg);
                    wdata = mpv ? '0 : {2'b10, total_reg};
                end
                state_next = S_W3;
            end
            S_W3:
            begin
                we = (func_reg == FUNC_FREE) && mpv;
                waddr = pv_reg;
                wdata = {2'b10, total_reg};
                idx_next = '0;
                lmax_next = '0;
                state_next = S_LSCAN;
            end
            S_OUT:
            begin
                if (!ov_reg || m_axis_tready)
                begin
                    ov_next = 1'b1;
                    od_next = {7'b0, changed_reg, lsat[7:0], empty_reg, bytes_reg,
                               addr_reg, status_reg};
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;  idx_reg <= '0;   dv_reg <= 1'b0;
            base_reg <= '0;        ov_reg <= 1'b0;
            fpc_reg <= (IW+1)'(UNITS - 1);
            largest_reg <= RW'(UNITS - 1);
        end
        else
        begin
            state_reg <= state_next; idx_reg <= idx_next; dv_reg <= dv_next;
            base_reg <= base_next;   ov_reg <= ov_next;
            fpc_reg <= fpc_next;     largest_reg <= largest_next;
        end
    end

    always_ff @(posedge clk)
    begin
        didx_reg <= didx_next;   func_reg <= func_next;   need_reg <= need_next;
        page_reg <= page_next;   bad_reg <= bad_next;
        best_reg <= best_next;   bsize_reg <= bsize_next; bfound_reg <= bfound_next;
        pv_reg <= pv_next;       pvf_reg <= pvf_next;     pvfree_reg <= pvfree_next;
        pvrun_reg <= pvrun_next; pgs_reg <= pgs_next;     pgu_reg <= pgu_next;
        nx_reg <= nx_next;       nxf_reg <= nxf_next;     nxfree_reg <= nxfree_next;
        nxrun_reg <= nxrun_next; total_reg <= total_next; lmax_reg <= lmax_next;
        changed_reg <= changed_next; status_reg <= status_next;
        addr_reg <= addr_next;   bytes_reg <= bytes_next; empty_reg <= empty_next;
        od_reg <= od_next;
    end

    `ASSERT_IMPLIES(a_no_take_in_clear, clk, rst_n, state_reg == S_CLEAR, !s_axis_tready)
    `ASSERT_IMPLIES(a_no_write_in_scan, clk, rst_n,
                    state_reg == S_SCAN || state_reg == S_LSCAN, !we)
    `ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, in_acc, state_reg != S_IDLE)
endmodule
`default_nettype wire
